### src/crcms_pkg.sv
// crcms_pkg: types, constants and the per-byte polynomial term for the byte stream crc core
// no dependencies; imported by crcms_step, crc32_msb_first_byte_stream_core and tb
package crcms_pkg;

   localparam int unsigned CRC_W     = 32;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned CNT_W     = 3;
   localparam int unsigned PACK_BYTES = 4;

   localparam logic [CRC_W-1:0] RESET_POLY = 32'h04C1_1DB7;
   localparam logic [CRC_W-1:0] TOP_BIT    = 32'h8000_0000;
   localparam logic [CNT_W-1:0] CNT_FULL   = 3'd4;

   typedef enum logic [CNT_W-1:0] {
      SLOT_B3 = 3'd0,
      SLOT_B2 = 3'd1,
      SLOT_B1 = 3'd2,
      SLOT_B0 = 3'd3
   } slot_type;

   typedef struct packed {
      logic [CRC_W-1:0] acc;
      logic [CNT_W-1:0] count;
   } crc_state_type;

   // eight msb-first shift/xor steps on a byte placed in the top of the word
   function automatic logic [CRC_W-1:0] byte_term(input logic [BYTE_W-1:0] idx,
                                                  input logic [CRC_W-1:0]  poly);
      logic [CRC_W-1:0] v;
      v = {idx, {(CRC_W-BYTE_W){1'b0}}};
      for (int s = 0; s < BYTE_W; s++) begin
         if ((v & TOP_BIT) != '0) begin
            v = {v[CRC_W-2:0], 1'b0} ^ poly;
         end else begin
            v = {v[CRC_W-2:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

### src/crcms_step.sv
// crcms_step: combinational next-state and result for one message byte
// depends on crcms_pkg (state type, byte_term)
module crcms_step (
   input  crcms_pkg::crc_state_type   cur_state,
   input  logic [7:0]                 data_byte,
   input  logic [31:0]                poly,
   output crcms_pkg::crc_state_type   next_state,
   output logic [31:0]                result
);
   import crcms_pkg::*;

   logic [CRC_W-1:0] placed;
   logic [CRC_W-1:0] packed_word;
   logic [CRC_W-1:0] shifted;

   always_comb begin
      placed = '0;
      case (cur_state.count)
         SLOT_B3: placed = {data_byte, 24'h0};
         SLOT_B2: placed = {8'h0, data_byte, 16'h0};
         SLOT_B1: placed = {16'h0, data_byte, 8'h0};
         SLOT_B0: placed = {24'h0, data_byte};
         default: placed = '0;
      endcase
   end

   assign packed_word = cur_state.acc | placed;
   assign shifted = {cur_state.acc[CRC_W-BYTE_W-1:0], data_byte}
                    ^ byte_term(cur_state.acc[CRC_W-1 -: BYTE_W], poly);

   always_comb begin
      if (cur_state.count < CNT_FULL) begin
         result           = packed_word;
         next_state.acc   = (cur_state.count == SLOT_B0) ? ~packed_word : packed_word;
         next_state.count = cur_state.count + 3'd1;
      end else begin
         result           = ~shifted;
         next_state.acc   = shifted;
         next_state.count = cur_state.count;
      end
   end

endmodule

### src/crc32_msb_first_byte_stream_core.sv
// crc32_msb_first_byte_stream_core: byte-serial msb-first crc-32 with configurable polynomial
// depends on crcms_pkg and crcms_step
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------
//  req_     | in        | tdata[7:0] data byte, tlast last byte of message
//  rsp_     | out       | tdata[31:0] crc value, one per message
//  csr_     | in        | wdata[31:0] polynomial, reset 0x04C11DB7
//
//  one byte per cycle while no last byte waits on a stalled result; req to rsp is registered
//  the input register feeds one combinational byte update into the accumulator
//  and the result register; a stalled result only holds back a last byte
//  reset (synchronous) clears the accumulator, byte count and both valids, and reloads the polynomial
module crc32_msb_first_byte_stream_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] crc_value
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata
);
   import crcms_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;
   logic [CRC_W-1:0]  poly_ff;
   crc_state_type     state_ff, state_in;
   crc_state_type     step_state;
   logic [CRC_W-1:0]  step_result;
   logic              out_valid_ff, out_valid_in;
   logic [CRC_W-1:0]  out_data_ff;
   logic              out_free;
   logic              in_advance;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign in_advance = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || in_advance;
   assign csr_ready  = 1'b1;

   crcms_step u_step (
      .cur_state (state_ff),
      .data_byte (in_byte_ff),
      .poly      (poly_ff),
      .next_state(step_state),
      .result    (step_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (in_advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (in_advance) begin
         if (in_last_ff) begin
            state_in = '0;
         end else begin
            state_in = step_state;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (in_advance && in_last_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         poly_ff      <= RESET_POLY;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         if (csr_valid && csr_ready) begin
            poly_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (in_advance && in_last_ff) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

`ifndef SYNTHESIS
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      state_ff.count <= CNT_FULL)
      else $error("byte count above saturation");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (in_advance && in_last_ff) |=> (state_ff.count == '0 && state_ff.acc == '0))
      else $error("state not cleared after last byte");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (in_advance && in_last_ff) |=> rsp_tvalid)
      else $error("last byte produced no response");

   a_stall_only_last: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !in_advance) |-> (in_last_ff && rsp_tvalid && !rsp_tready))
      else $error("input stage stalled without a blocked response");
`endif

endmodule

### dv/tb.sv
// tb: self-checking bench for crc32_msb_first_byte_stream_core, directed rows then random messages
// depends on crcms_pkg for widths and constants; drives the req_, rsp_ and csr_ channels
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import crcms_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int PHASES = 6;
   localparam int PHASE_BYTES = 180;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              known;
      logic [CRC_W-1:0]  crc;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid;
   logic              req_tready;
   logic [7:0]        req_tdata;   // [7:0] data_byte
   logic              req_tlast;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;   // [31:0] crc_value
   logic              csr_valid;
   logic              csr_ready;
   logic [31:0]       csr_wdata;

   // predictor state
   logic [CRC_W-1:0]  crc_acc;
   logic [CNT_W-1:0]  crc_count;
   logic [CRC_W-1:0]  crc_poly;
   logic [CRC_W-1:0]  pending_crcs [$];
   int                mismatch_count = 0;
   int                send_idle = 0;
   int                recv_stall = 0;

   int send_idle_pct [PHASES] = '{0, 66, 0, 24, 66, 0};
   int recv_stall_pct [PHASES] = '{0, 0, 66, 24, 0, 66};

   // short messages, the extremes of each byte, then a message left open
   stim_row_type directed_rows [25] = '{
      '{8'hFF, 1'b1, 1'b1, 32'hFF00_0000},
      '{8'h00, 1'b1, 1'b1, 32'h0000_0000},
      '{8'h12, 1'b0, 1'b0, 32'h0},
      '{8'h34, 1'b1, 1'b1, 32'h1234_0000},
      '{8'h01, 1'b0, 1'b0, 32'h0},
      '{8'h02, 1'b0, 1'b0, 32'h0},
      '{8'h03, 1'b1, 1'b1, 32'h0102_0300},
      '{8'hAA, 1'b0, 1'b0, 32'h0},
      '{8'hBB, 1'b0, 1'b0, 32'h0},
      '{8'hCC, 1'b0, 1'b0, 32'h0},
      '{8'hDD, 1'b1, 1'b1, 32'hAABB_CCDD},
      '{8'hFF, 1'b0, 1'b0, 32'h0},
      '{8'hFF, 1'b0, 1'b0, 32'h0},
      '{8'hFF, 1'b0, 1'b0, 32'h0},
      '{8'hFF, 1'b0, 1'b0, 32'h0},
      '{8'h00, 1'b1, 1'b0, 32'h0},
      '{8'h00, 1'b0, 1'b0, 32'h0},
      '{8'h00, 1'b0, 1'b0, 32'h0},
      '{8'h00, 1'b0, 1'b0, 32'h0},
      '{8'h00, 1'b0, 1'b0, 32'h0},
      '{8'hFF, 1'b0, 1'b0, 32'h0},
      '{8'h80, 1'b1, 1'b0, 32'h0},
      '{8'h5A, 1'b0, 1'b0, 32'h0},
      '{8'hC3, 1'b0, 1'b0, 32'h0},
      '{8'h7E, 1'b0, 1'b0, 32'h0}
   };

   crc32_msb_first_byte_stream_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // term for the byte leaving the top of the register
   function automatic logic [CRC_W-1:0] poly_fold(input logic [BYTE_W-1:0] top,
                                                  input logic [CRC_W-1:0]  poly);
      logic [CRC_W-1:0] w;
      w = {top, {(CRC_W-BYTE_W){1'b0}}};
      repeat (BYTE_W) w = w[CRC_W-1] ? ((w << 1) ^ poly) : (w << 1);
      return w;
   endfunction

   function automatic logic [CRC_W-1:0] absorb_byte(input logic [BYTE_W-1:0] b,
                                                    input logic              last);
      logic [CRC_W-1:0] packed_word;
      logic [CRC_W-1:0] crc_out;
      int               shift;
      if (crc_count < CNT_FULL) begin
         shift = int'(BYTE_W) * (int'(PACK_BYTES) - 1 - int'(crc_count));
         packed_word = crc_acc | (CRC_W'(b) << shift);
         crc_out = packed_word;
         // fourth byte completes the packed word, which is then inverted
         crc_acc = (slot_type'(crc_count) == SLOT_B0) ? ~packed_word : packed_word;
         crc_count = crc_count + 1'b1;
      end else begin
         crc_acc = {crc_acc[CRC_W-BYTE_W-1:0], b} ^ poly_fold(crc_acc[CRC_W-1 -: BYTE_W],
                                                             crc_poly);
         crc_out = ~crc_acc;
      end
      if (last) begin
         crc_acc = '0;
         crc_count = '0;
      end
      return crc_out;
   endfunction

   task automatic note_mismatch(input string what, input logic [CRC_W-1:0] exp_crc,
                                input logic [CRC_W-1:0] got_crc);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("tb: %s crc_value expected %h got %h", what, exp_crc, got_crc);
   endtask

   // entered and left at a falling edge
   task automatic push_byte(input logic [BYTE_W-1:0] data, input logic last,
                            input logic known, input logic [CRC_W-1:0] typed_crc);
      logic [CRC_W-1:0] crc_out;
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      crc_out = absorb_byte(data, last);
      if (last)
         pending_crcs.push_back(known ? typed_crc : crc_out);
      @(negedge clock);
   endtask

   // only with nothing in flight; an open message keeps its state
   task automatic write_poly(input logic [CRC_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_crcs.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      crc_poly = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (!reset)
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_crcs.size() == 0)
            note_mismatch("unexpected transaction,", '0, rsp_tdata);
         else if (rsp_tdata !== pending_crcs[0])
            note_mismatch("mismatch,", pending_crcs.pop_front(), rsp_tdata);
         else
            void'(pending_crcs.pop_front());
      end
   end

   initial begin
      logic [CRC_W-1:0] phase_polys [PHASES];
      int               msg_left;
      int               sel;
      logic             last;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      crc_acc = '0;
      crc_count = '0;
      crc_poly = RESET_POLY;
      msg_left = 0;
      phase_polys = '{32'hFFFF_FFFF, 32'h0, $urandom(), 32'h0000_0001, TOP_BIT, RESET_POLY};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_poly(RESET_POLY);
      foreach (directed_rows[i])
         push_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].known,
                   directed_rows[i].crc);

      for (int p = 0; p < PHASES; p++) begin
         // the first change lands in the middle of the open directed message
         write_poly(phase_polys[p]);
         send_idle = send_idle_pct[p];
         recv_stall = recv_stall_pct[p];
         for (int n = 0; n < PHASE_BYTES; n++) begin
            if (msg_left == 0) begin
               sel = $urandom_range(0, 9);
               msg_left = (sel < 6) ? $urandom_range(1, 8) :
                          (sel < 9) ? $urandom_range(9, 24) : $urandom_range(25, 64);
            end
            last = (msg_left == 1) || (p == PHASES - 1 && n == PHASE_BYTES - 1);
            push_byte(8'($urandom_range(0, 255)), last, 1'b0, '0);
            msg_left = last ? 0 : msg_left - 1;
         end
      end

      req_tvalid <= 1'b0;
      while (pending_crcs.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_crcs.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
